### hw/rtl/trms_pkg.sv
package trms_pkg;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 37;
  localparam int CNT_W    = 7;
  localparam int RMS_W    = 24;

  // Defined samples accumulated per trace; later ones are dropped.
  localparam int MAX_SAMPLES = 64;

  // Divider: {sum, 16 zero bits} padded to an even width, two bits per cycle.
  localparam int FRAC_W    = 16;
  localparam int DVD_W     = 54;
  localparam int DIV_STEPS = DVD_W / 2;

  // Square root: 48-bit radicand, two radicand bits per cycle.
  localparam int RAD_W      = 48;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SREM_W     = ROOT_W + 2;

  localparam int STEP_W = 5;

  // One finished trace, handed from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } trms_job_t;

  // Status of the job queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } trms_qstat_t;

endpackage

### hw/rtl/trms_front.sv
module trms_front
  import trms_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_undefined,
  input  logic                       in_last,
  input  trms_qstat_t                q_stat,
  output logic                       q_push,
  output trms_job_t                  q_job
);

  logic                  a_vld_r;
  logic [SAMPLE_W-1:0]   a_mag_r;
  logic                  a_undef_r;
  logic                  a_last_r;
  logic                  b_vld_r;
  logic [SQ_W-1:0]       b_sq_r;
  logic                  b_undef_r;
  logic                  b_last_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SUM_W-1:0]      sum_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [SAMPLE_W-1:0]   mag;
  logic [2*SAMPLE_W-1:0] prod;
  logic                  stall;
  logic                  take;
  logic                  add_en;
  logic                  trace_end;
  logic [SUM_W-1:0]      sum_add;
  logic [CNT_W-1:0]      cnt_add;

  // The pipeline holds while a finished trace cannot enter the queue.
  assign trace_end = b_vld_r & b_last_r;
  assign stall     = trace_end & q_stat.full;
  assign take      = in_push & ~stall;
  assign in_full   = stall;

  // Magnitude of the two's complement sample; the most negative value gives 32768.
  assign mag  = in_sample[SAMPLE_W-1] ? (SAMPLE_W'(0) - SAMPLE_W'(in_sample))
                                      : SAMPLE_W'(in_sample);
  assign prod = a_mag_r * a_mag_r;

  // Accumulate defined samples until the count reaches its limit.
  assign add_en  = b_vld_r & ~b_undef_r & (cnt_r < CNT_W'(MAX_SAMPLES));
  assign sum_add = add_en ? (sum_r + SUM_W'(b_sq_r)) : sum_r;
  assign cnt_add = add_en ? (cnt_r + CNT_W'(1)) : cnt_r;

  // The last sample hands the totals to the queue and clears them.
  assign q_push    = trace_end & ~q_stat.full;
  assign q_job.sum = sum_add;
  assign q_job.cnt = cnt_add;
  assign sum_nxt   = trace_end ? '0 : sum_add;
  assign cnt_nxt   = trace_end ? '0 : cnt_add;

  // Control state and accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else if (!stall) begin
      a_vld_r <= take;
      b_vld_r <= a_vld_r;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Sample payload: magnitude first, then its square.
  always_ff @(posedge clk) begin
    if (!stall) begin
      a_mag_r   <= mag;
      a_undef_r <= in_undefined;
      a_last_r  <= in_last;
      b_sq_r    <= prod[SQ_W-1:0];
      b_undef_r <= a_undef_r;
      b_last_r  <= a_last_r;
    end
  end

endmodule

### hw/rtl/trms_queue.sv
module trms_queue
  import trms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  trms_job_t   push_job,
  input  logic        pop,
  output trms_job_t   pop_job,
  output trms_qstat_t stat
);

  trms_job_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign pop_job    = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // The front never offers a job to a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("job offered to a full queue");

  // The back never takes from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("job taken from an empty queue");

endmodule

### hw/rtl/trms_back.sv
module trms_back
  import trms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  trms_qstat_t      q_stat,
  input  trms_job_t        q_job,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [RMS_W-1:0] out_rms_q8,
  output logic [CNT_W-1:0] out_defined_count,
  output logic             out_empty_res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SQRT = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]        state_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  rem_r;
  logic [RAD_W-1:0]  rad_r;
  logic [SREM_W-1:0] srem_r;
  logic [ROOT_W-1:0] root_r;
  logic [RMS_W-1:0]  res_rms_r;
  logic              res_empty_r;
  logic              out_vld_r;
  logic [RMS_W-1:0]  out_rms_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_empty_res_r;

  logic [CNT_W:0]    div_d;
  logic [CNT_W:0]    r2a;
  logic [CNT_W:0]    r2b;
  logic [CNT_W:0]    ra;
  logic [CNT_W:0]    rb;
  logic              ge_a;
  logic              ge_b;
  logic [DVD_W-1:0]  dvd_nxt;
  logic [SREM_W+1:0] srem2;
  logic [SREM_W+1:0] trial;
  logic              ge_s;
  logic [SREM_W+1:0] srem_diff;
  logic [SREM_W-1:0] srem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic              load_out;

  // Divider: two restoring steps per cycle on a remainder below the count.
  assign div_d   = {1'b0, cnt_r};
  assign r2a     = {rem_r, dvd_r[DVD_W-1]};
  assign ge_a    = (r2a >= div_d);
  assign ra      = ge_a ? (r2a - div_d) : r2a;
  assign r2b     = {ra[CNT_W-1:0], dvd_r[DVD_W-2]};
  assign ge_b    = (r2b >= div_d);
  assign rb      = ge_b ? (r2b - div_d) : r2b;
  assign dvd_nxt = {dvd_r[DVD_W-3:0], ge_a, ge_b};

  // Square root: one result bit per cycle from the top two radicand bits.
  assign srem2     = {srem_r, rad_r[RAD_W-1 -: 2]};
  assign trial     = {2'b00, root_r, 2'b01};
  assign ge_s      = (srem2 >= trial);
  assign srem_diff = srem2 - trial;
  assign srem_nxt  = ge_s ? srem_diff[SREM_W-1:0] : srem2[SREM_W-1:0];
  assign root_nxt  = {root_r[ROOT_W-2:0], ge_s};

  assign q_pop    = (state_r == S_IDLE) & ~q_stat.empty;
  assign load_out = (state_r == S_HOLD) & (~out_vld_r | out_pop);

  // Sequencer and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            step_r  <= '0;
            state_r <= (q_job.cnt == '0) ? S_HOLD : S_DIV;
          end
        end
        S_DIV: begin
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            step_r  <= '0;
            state_r <= S_SQRT;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_SQRT: begin
          if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
            step_r  <= '0;
            state_r <= S_HOLD;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_HOLD: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      out_vld_r <= load_out | (out_vld_r & ~out_pop);
    end
  end

  // Datapath registers of the divider, the root and the result.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cnt_r       <= q_job.cnt;
        dvd_r       <= {1'b0, q_job.sum, FRAC_W'(0)};
        rem_r       <= '0;
        res_rms_r   <= '0;
        res_empty_r <= 1'b1;
      end
      S_DIV: begin
        dvd_r  <= dvd_nxt;
        rem_r  <= rb[CNT_W-1:0];
        rad_r  <= dvd_nxt[RAD_W-1:0];
        srem_r <= '0;
        root_r <= '0;
      end
      S_SQRT: begin
        rad_r       <= {rad_r[RAD_W-3:0], 2'b00};
        srem_r      <= srem_nxt;
        root_r      <= root_nxt;
        res_rms_r   <= root_nxt[RMS_W-1:0];
        res_empty_r <= 1'b0;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_rms_r       <= res_rms_r;
      out_cnt_r       <= cnt_r;
      out_empty_res_r <= res_empty_r;
    end
  end

  assign out_empty         = ~out_vld_r;
  assign out_rms_q8        = out_rms_r;
  assign out_defined_count = out_cnt_r;
  assign out_empty_res     = out_empty_res_r;

  // An empty trace reports a zero root and a zero count.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_empty_res) |-> (out_rms_q8 == '0 && out_defined_count == '0))
    else $error("empty trace with nonzero result");

  // The divider hands over to the root after its last step.
  a_div_to_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r == STEP_W'(DIV_STEPS - 1)) |=> (state_r == S_SQRT))
    else $error("divider did not hand over to the root");

  // A job taken from the queue starts the divider or goes straight to the result.
  a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_DIV || state_r == S_HOLD))
    else $error("job taken without starting");

endmodule

### hw/rtl/trace_rms_skip_undefined_unit.sv
// Throughput: one sample per cycle while in_full is low; the back end takes a new trace only
// once the last result is loaded (divider at two quotient bits per step, square root, load).
// Path of a trace: magnitude, square, accumulation, queue, divider, square root and result
// register; a trace with no defined sample skips the divider and the square root.
// A two-entry job queue lets the front keep sampling while the back end works on earlier traces.
// Reset (synchronous, active low) clears the sum, the count, the queue and the result valid flag.

module trace_rms_skip_undefined_unit
  import trms_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_undefined,
  input  logic                       in_last,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [RMS_W-1:0]           out_rms_q8,
  output logic [CNT_W-1:0]           out_defined_count,
  output logic                       out_empty_res
);

  trms_qstat_t q_stat;
  trms_job_t   push_job;
  trms_job_t   pop_job;
  logic        q_push;
  logic        q_pop;

  // Sample intake, squaring and accumulation.
  trms_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_sample    (in_sample),
    .in_undefined (in_undefined),
    .in_last      (in_last),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  // Finished traces waiting for the back end.
  trms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  // Division, square root and result register.
  trms_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_job             (pop_job),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_rms_q8        (out_rms_q8),
    .out_defined_count (out_defined_count),
    .out_empty_res     (out_empty_res)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb
  import trms_pkg::*;
();

  localparam int ITEM_TARGET = 600;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 120;

  // One expected RMS result of a finished trace.
  typedef struct packed {
    logic [RMS_W-1:0] rms_q8;
    logic [CNT_W-1:0] defined_count;
    logic             empty_res;
  } rms_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_undefined = 1'b0;
  logic                       in_last = 1'b0;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic [RMS_W-1:0]           out_rms_q8;
  logic [CNT_W-1:0]           out_defined_count;
  logic                       out_empty_res;

  rms_result_t     expected_rms_q[$];
  longint unsigned acc_sum = 0;
  int              acc_cnt = 0;
  int              error_count = 0;
  int              samples_sent = 0;
  int              quiet_cycles = 0;
  int              pop_hold = 0;
  bit              steady_flow = 1'b0;

  trace_rms_skip_undefined_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_sample        (in_sample),
    .in_undefined     (in_undefined),
    .in_last          (in_last),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_rms_q8       (out_rms_q8),
    .out_defined_count(out_defined_count),
    .out_empty_res    (out_empty_res)
  );

  always #5 clk = ~clk;

  // Idle length: mostly short, now and then long.
  function automatic int pick_gap();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(45, 15);
    end
    return $urandom_range(3);
  endfunction

  // Floor of the square root, built one root bit at a time from the top.
  function automatic logic [RMS_W-1:0] root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 26; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) begin
        r = t;
      end
    end
    return r[RMS_W-1:0];
  endfunction

  // Accumulate a defined sample below the limit; queue the trace result on its last mark.
  task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] s, input logic undef,
                                   input logic lst);
    longint unsigned mag;
    rms_result_t     res;
    if (!undef && acc_cnt < MAX_SAMPLES) begin
      mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
      acc_sum += mag * mag;
      acc_cnt++;
    end
    if (lst) begin
      if (acc_cnt == 0) begin
        res = '{rms_q8: '0, defined_count: '0, empty_res: 1'b1};
      end else begin
        res.rms_q8        = root_floor((acc_sum << FRAC_W) / longint'(acc_cnt));
        res.defined_count = acc_cnt[CNT_W-1:0];
        res.empty_res     = 1'b0;
      end
      expected_rms_q.push_back(res);
      acc_sum = 0;
      acc_cnt = 0;
    end
  endtask

  // Sample both channels at each edge: predict on input transfers, check result transfers.
  always @(posedge clk) begin
    rms_result_t exp_res;
    bit          moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_push && !in_full) begin
        accumulate_sample(in_sample, in_undefined, in_last);
        moved = 1'b1;
      end
      if (out_pop && !out_empty) begin
        moved = 1'b1;
        if (expected_rms_q.size() == 0) begin
          $display("%0t: result transfer with no expectation: rms_q8 %0d count %0d empty %0d",
                   $time, out_rms_q8, out_defined_count, out_empty_res);
          error_count++;
        end else begin
          exp_res = expected_rms_q.pop_front();
          if (out_rms_q8 !== exp_res.rms_q8) begin
            $display("%0t: rms_q8 expected %0d, actual %0d", $time, exp_res.rms_q8, out_rms_q8);
            error_count++;
          end
          if (out_defined_count !== exp_res.defined_count) begin
            $display("%0t: defined_count expected %0d, actual %0d", $time,
                     exp_res.defined_count, out_defined_count);
            error_count++;
          end
          if (out_empty_res !== exp_res.empty_res) begin
            $display("%0t: empty_res expected %0d, actual %0d", $time,
                     exp_res.empty_res, out_empty_res);
            error_count++;
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: random stalls of the pop, no new ones while steady flow is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop  <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold != 0) begin
      out_pop  <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (steady_flow || $urandom_range(3) != 0) begin
      out_pop <= 1'b1;
    end else begin
      out_pop  <= 1'b0;
      pop_hold <= pick_gap();
    end
  end

  // Offer one sample, after a random gap unless steady flow is on, and hold it until the transfer.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic undef,
                             input logic lst);
    int gap;
    gap = (steady_flow || $urandom_range(2) != 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_sample    <= s;
    in_undefined <= undef;
    in_last      <= lst;
    do @(posedge clk); while (in_full);
    samples_sent++;
  endtask

  // Amplitude with extra weight on the extremes and on tiny values.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(7))
      0: s = 16'sh8000;
      1: s = 16'sh7fff;
      2: s = $urandom_range(1) ? SAMPLE_W'($urandom_range(15)) : -SAMPLE_W'($urandom_range(15));
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  // Send one trace of the given length; undefined marks come at the given odds (out of 8).
  task automatic send_trace(input int len, input int undef_odds);
    for (int i = 0; i < len; i++) begin
      send_sample(pick_sample(), $urandom_range(7) < undef_odds, i == len - 1);
    end
  endtask

  task automatic wait_for_results();
    while (expected_rms_q.size() != 0) @(posedge clk);
  endtask

  // Single-sample traces at the amplitude extremes, then short mixed ones.
  task automatic test_extremes();
    send_sample(16'sh8000, 1'b0, 1'b1);
    send_sample(16'sh7fff, 1'b0, 1'b1);
    send_sample(16'sh0000, 1'b0, 1'b1);
    send_sample(-16'sd1, 1'b0, 1'b0);
    send_sample(16'sd1, 1'b0, 1'b1);
    send_sample(16'sh7fff, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b0);
    send_sample(16'sh0000, 1'b0, 1'b1);
  endtask

  // Traces in which no sample is defined give the empty flag.
  task automatic test_empty_traces();
    send_sample(16'sh7fff, 1'b1, 1'b1);
    send_sample(16'sh8000, 1'b1, 1'b0);
    send_sample(16'sh5555, 1'b1, 1'b0);
    send_sample(-16'sd1, 1'b1, 1'b1);
  endtask

  // An undefined last sample is skipped but still closes the trace.
  task automatic test_undefined_last();
    send_sample(16'sd100, 1'b0, 1'b0);
    send_sample(-16'sd200, 1'b0, 1'b0);
    send_sample(16'sh7fff, 1'b1, 1'b1);
  endtask

  // Defined samples beyond the per-trace maximum are dropped.
  task automatic test_count_saturation();
    for (int i = 0; i < MAX_SAMPLES + 6; i++) begin
      send_sample(i < MAX_SAMPLES ? pick_sample() : 16'sh8000, 1'b0, i == MAX_SAMPLES + 5);
    end
    for (int i = 0; i < MAX_SAMPLES + 2; i++) begin
      send_sample(pick_sample(), i % 9 == 4, i == MAX_SAMPLES + 1);
    end
  endtask

  // The sender holds off until the back end has delivered every result.
  task automatic test_drain_pause();
    send_trace(3, 1);
    send_trace(1, 0);
    in_push <= 1'b0;
    wait_for_results();
    send_trace(5, 2);
  endtask

  // Random traces: mostly short, a few long ones near or past the sample maximum, some fully undefined.
  task automatic test_random_traces();
    int trace_no;
    int len;
    trace_no = 0;
    while (samples_sent < ITEM_TARGET) begin
      // Alternate stretches with and without idling on both sides.
      steady_flow = (trace_no % 16) >= 12;
      len = ($urandom_range(19) == 0) ? $urandom_range(80, 60) : $urandom_range(12, 1);
      send_trace(len, ($urandom_range(7) == 0) ? 8 : $urandom_range(2));
      if ($urandom_range(24) == 0) begin
        in_push <= 1'b0;
        wait_for_results();
      end
      trace_no++;
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_empty_traces();
    test_undefined_last();
    test_drain_pause();
    test_count_saturation();
    test_random_traces();
    in_push <= 1'b0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
